// ===== rtl/iie_pkg.sv =====
// Shared types, constants and helper functions for the soft switch controller.
`timescale 1ns / 1ps

package iie_pkg;

    // Bit positions within the mode flag word.
    localparam int unsigned F_80STORE  = 0;
    localparam int unsigned F_RAMRD    = 1;
    localparam int unsigned F_RAMWRT   = 2;
    localparam int unsigned F_INTCXROM = 3;
    localparam int unsigned F_ALTZP    = 4;
    localparam int unsigned F_SLOTC3   = 5;
    localparam int unsigned F_COL80    = 6;
    localparam int unsigned F_ALTCHAR  = 7;
    localparam int unsigned F_TEXT     = 8;
    localparam int unsigned F_MIXED    = 9;
    localparam int unsigned F_PAGE2    = 10;
    localparam int unsigned F_HIRES    = 11;
    localparam int unsigned F_DHIRES   = 12;
    localparam int unsigned F_BANK2    = 13;
    localparam int unsigned F_LCREAD   = 14;
    localparam int unsigned F_LCWRITE  = 15;

    localparam int unsigned FLAG_W = 16;

    // Paddle RC timer span and the timer's full-scale count.
    localparam logic [11:0] PADDLE_SPAN = 12'd3061;
    localparam logic [7:0]  TIMER_MAX   = 8'd255;

    // Status byte encodings.
    localparam logic [7:0] STATUS_SET = 8'h80;
    localparam logic [7:0] STROBE_CLR = 8'h7F;

    // Machine model codes.
    localparam logic [1:0] MODEL_OLDER    = 2'd0;
    localparam logic [1:0] MODEL_BASE     = 2'd1;
    localparam logic [1:0] MODEL_ENHANCED = 2'd2;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_LOAD_KEY = 2'd2,
        OP_RESET    = 2'd3
    } iie_op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  key_code;
        logic [2:0]  buttons;
        logic [31:0] paddle_axes;
        logic [31:0] now_cycle;
        logic        in_vbl;
    } iie_item_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              driven;
        logic [FLAG_W-1:0] mode_flags;
        logic              speaker_out;
        logic              int_exp_rom;
        logic [2:0]        last_slot;
    } iie_view_t;

    function automatic logic [FLAG_W-1:0] flag_mask(input int unsigned pos);
        logic [FLAG_W-1:0] m;
        m = '0;
        m[pos] = 1'b1;
        return m;
    endfunction

    function automatic logic [FLAG_W-1:0] set_or_clear(input logic [FLAG_W-1:0] f,
                                                        input logic [FLAG_W-1:0] m,
                                                        input logic on);
        return on ? (f | m) : (f & ~m);
    endfunction

    // Switches written at $C000-$C00F, one per address pair.
    function automatic logic [FLAG_W-1:0] low_switch(input logic [2:0] idx);
        logic [FLAG_W-1:0] m;
        case (idx)
            3'd0:    m = flag_mask(F_80STORE);
            3'd1:    m = flag_mask(F_RAMRD);
            3'd2:    m = flag_mask(F_RAMWRT);
            3'd3:    m = flag_mask(F_INTCXROM);
            3'd4:    m = flag_mask(F_ALTZP);
            3'd5:    m = flag_mask(F_SLOTC3);
            3'd6:    m = flag_mask(F_COL80);
            default: m = flag_mask(F_ALTCHAR);
        endcase
        return m;
    endfunction

    // Flag reported in bit 7 at $C011-$C01F ($C019 excepted).
    function automatic logic [FLAG_W-1:0] status_bit(input logic [3:0] idx);
        logic [FLAG_W-1:0] m;
        case (idx)
            4'h1:    m = flag_mask(F_BANK2);
            4'h2:    m = flag_mask(F_LCREAD);
            4'h3:    m = flag_mask(F_RAMRD);
            4'h4:    m = flag_mask(F_RAMWRT);
            4'h5:    m = flag_mask(F_INTCXROM);
            4'h6:    m = flag_mask(F_ALTZP);
            4'h7:    m = flag_mask(F_SLOTC3);
            4'h8:    m = flag_mask(F_80STORE);
            4'hA:    m = flag_mask(F_TEXT);
            4'hB:    m = flag_mask(F_MIXED);
            4'hC:    m = flag_mask(F_PAGE2);
            4'hD:    m = flag_mask(F_HIRES);
            4'hE:    m = flag_mask(F_ALTCHAR);
            4'hF:    m = flag_mask(F_COL80);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [FLAG_W-1:0] video_switch(input logic [1:0] idx);
        logic [FLAG_W-1:0] m;
        case (idx)
            2'd0:    m = flag_mask(F_TEXT);
            2'd1:    m = flag_mask(F_MIXED);
            2'd2:    m = flag_mask(F_PAGE2);
            default: m = flag_mask(F_HIRES);
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/iie_if.sv =====
// Channel interfaces: bus access requests, results and the model register write.
`timescale 1ns / 1ps

interface iie_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] address;
    logic [7:0]  key_code;
    logic [2:0]  buttons;
    logic [31:0] paddle_axes;
    logic [31:0] now_cycle;
    logic        in_vbl;

    modport source (output valid, op, address, key_code, buttons, paddle_axes,
                    now_cycle, in_vbl, input ready);
    modport sink   (input valid, op, address, key_code, buttons, paddle_axes,
                    now_cycle, in_vbl, output ready);
endinterface

interface iie_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        driven;
    logic [15:0] mode_flags;
    logic        speaker_out;
    logic        int_exp_rom;
    logic [2:0]  last_slot;

    modport source (output valid, read_data, driven, mode_flags, speaker_out,
                    int_exp_rom, last_slot, input ready);
    modport sink   (input valid, read_data, driven, mode_flags, speaker_out,
                    int_exp_rom, last_slot, output ready);
endinterface

interface iie_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] machine_model;

    modport source (output valid, machine_model, input ready);
    modport sink   (input valid, machine_model, output ready);
endinterface

// ===== rtl/iie_paddle.sv =====
// Paddle comparator: reports whether the RC timer is still at or below an axis.
`timescale 1ns / 1ps

module iie_paddle
(
    input  logic [31:0] now_cycle,
    input  logic [31:0] trigger_cycle,
    input  logic [7:0]  axis,
    output logic        active
);

    logic [31:0] elapsed;
    logic        expired;
    logic [19:0] scaled_time;
    logic [19:0] axis_limit;

    // timer = elapsed*255/span, and timer <= axis exactly when
    // elapsed*255 < (axis+1)*span, so no divider is needed.
    assign elapsed     = now_cycle - trigger_cycle;
    assign expired     = elapsed >= {20'd0, iie_pkg::PADDLE_SPAN};
    assign scaled_time = 20'(elapsed[11:0]) * 20'(iie_pkg::TIMER_MAX);
    assign axis_limit  = (20'(axis) + 20'd1) * 20'(iie_pkg::PADDLE_SPAN);

    always_comb
    begin
        if (expired)
            active = (axis == iie_pkg::TIMER_MAX);
        else
            active = scaled_time < axis_limit;
    end

endmodule

// ===== rtl/iie_state.sv =====
// Switch state registers and the decode that updates them for one bus access.
`timescale 1ns / 1ps

module iie_state
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          machine_model,
    input  iie_pkg::iie_item_t  item,
    output iie_pkg::iie_view_t  view
);

    logic [iie_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic                       pre_write_reg, pre_write_next;
    logic [7:0]                 kbd_latch_reg, kbd_latch_next;
    logic                       speaker_reg, speaker_next;
    logic [31:0]                trigger_cycle_reg, trigger_cycle_next;
    logic                       c800_latch_reg, c800_latch_next;
    logic [2:0]                 io_slot_reg, io_slot_next;

    logic [7:0] sw_addr;
    logic       in_io_page;
    logic       in_slot_space;
    logic [7:0] paddle_axis;
    logic       paddle_active;
    logic [7:0] read_data;
    logic       driven;
    logic       lc_access;
    logic       lc_write;
    logic       video_access;

    assign sw_addr       = item.address[7:0];
    assign in_io_page    = item.address[15:8] == 8'hC0;
    assign in_slot_space = (item.address[15:11] == 5'b11000) && (item.address[10:8] != 3'd0);

    always_comb
    begin
        case (sw_addr[1:0])
            2'd0:    paddle_axis = item.paddle_axes[7:0];
            2'd1:    paddle_axis = item.paddle_axes[15:8];
            2'd2:    paddle_axis = item.paddle_axes[23:16];
            default: paddle_axis = item.paddle_axes[31:24];
        endcase
    end

    iie_paddle u_paddle
    (
        .now_cycle     (item.now_cycle),
        .trigger_cycle (trigger_cycle_reg),
        .axis          (paddle_axis),
        .active        (paddle_active)
    );

    always_comb
    begin
        flags_next         = flags_reg;
        pre_write_next     = pre_write_reg;
        kbd_latch_next     = kbd_latch_reg;
        speaker_next       = speaker_reg;
        trigger_cycle_next = trigger_cycle_reg;
        c800_latch_next    = c800_latch_reg;
        io_slot_next       = io_slot_reg;
        read_data          = '0;
        driven             = 1'b0;
        lc_access          = 1'b0;
        lc_write           = 1'b0;
        video_access       = 1'b0;

        case (iie_pkg::iie_op_t'(item.op))
            iie_pkg::OP_LOAD_KEY:
            begin
                kbd_latch_next = item.key_code;
            end
            iie_pkg::OP_RESET:
            begin
                flags_next = iie_pkg::flag_mask(iie_pkg::F_BANK2)
                           | iie_pkg::flag_mask(iie_pkg::F_LCWRITE)
                           | iie_pkg::flag_mask(iie_pkg::F_TEXT);
                if (machine_model == iie_pkg::MODEL_OLDER)
                    flags_next = flags_next | iie_pkg::flag_mask(iie_pkg::F_SLOTC3);
                pre_write_next  = 1'b1;
                c800_latch_next = 1'b0;
                io_slot_next    = '0;
            end
            iie_pkg::OP_READ:
            begin
                if (in_io_page)
                begin
                    case (sw_addr) inside
                        [8'h00:8'h0F]:
                        begin
                            read_data = kbd_latch_reg;
                            driven    = 1'b1;
                        end
                        8'h10:
                        begin
                            read_data      = kbd_latch_reg;
                            driven         = 1'b1;
                            kbd_latch_next = kbd_latch_reg & iie_pkg::STROBE_CLR;
                        end
                        8'h19:
                        begin
                            read_data = item.in_vbl ? iie_pkg::STATUS_SET : 8'h00;
                            driven    = 1'b1;
                        end
                        [8'h11:8'h1F]:
                        begin
                            read_data = |(flags_reg & iie_pkg::status_bit(sw_addr[3:0]))
                                      ? iie_pkg::STATUS_SET : 8'h00;
                            driven    = 1'b1;
                        end
                        [8'h30:8'h3F]:
                        begin
                            speaker_next = ~speaker_reg;
                        end
                        [8'h50:8'h57]:
                        begin
                            video_access = 1'b1;
                        end
                        [8'h61:8'h63]:
                        begin
                            read_data = item.buttons[sw_addr[1:0] - 2'd1]
                                      ? iie_pkg::STATUS_SET : 8'h00;
                            driven    = 1'b1;
                        end
                        [8'h64:8'h67]:
                        begin
                            read_data = paddle_active ? iie_pkg::STATUS_SET : 8'h00;
                            driven    = 1'b1;
                        end
                        [8'h70:8'h7F]:
                        begin
                            trigger_cycle_next = item.now_cycle;
                        end
                        [8'h80:8'h8F]:
                        begin
                            lc_access = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                // Write access.
                if (in_io_page)
                begin
                    case (sw_addr) inside
                        [8'h00:8'h0F]:
                        begin
                            if (machine_model == iie_pkg::MODEL_ENHANCED)
                                flags_next = iie_pkg::set_or_clear(flags_reg,
                                    iie_pkg::low_switch(sw_addr[3:1]), sw_addr[0]);
                        end
                        [8'h10:8'h1F]:
                        begin
                            kbd_latch_next = kbd_latch_reg & iie_pkg::STROBE_CLR;
                        end
                        [8'h30:8'h3F]:
                        begin
                            speaker_next = ~speaker_reg;
                        end
                        [8'h50:8'h5F]:
                        begin
                            video_access = 1'b1;
                        end
                        [8'h70:8'h7F]:
                        begin
                            trigger_cycle_next = item.now_cycle;
                        end
                        [8'h80:8'h8F]:
                        begin
                            lc_access = 1'b1;
                            lc_write  = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase

        // Read and write accesses outside the switch page.
        if (item.op == iie_pkg::OP_READ || item.op == iie_pkg::OP_WRITE)
        begin
            if (in_slot_space && !flags_reg[iie_pkg::F_INTCXROM])
            begin
                io_slot_next = item.address[10:8];
                if (!c800_latch_reg && item.address[10:8] == 3'd3
                    && !flags_reg[iie_pkg::F_SLOTC3])
                    c800_latch_next = 1'b1;
            end
            if (item.address == 16'hCFFF)
                c800_latch_next = 1'b0;
        end

        if (video_access)
        begin
            if (sw_addr < 8'h58)
                flags_next = iie_pkg::set_or_clear(flags_reg,
                    iie_pkg::video_switch(sw_addr[2:1]), sw_addr[0]);
            else if (sw_addr == 8'h5E)
                flags_next = flags_reg | iie_pkg::flag_mask(iie_pkg::F_DHIRES);
            else if (sw_addr == 8'h5F)
                flags_next = flags_reg & ~iie_pkg::flag_mask(iie_pkg::F_DHIRES);
        end

        if (lc_access)
        begin
            flags_next = iie_pkg::set_or_clear(flags_reg,
                iie_pkg::flag_mask(iie_pkg::F_BANK2), !sw_addr[3]);
            flags_next = iie_pkg::set_or_clear(flags_next,
                iie_pkg::flag_mask(iie_pkg::F_LCREAD),
                sw_addr[1:0] == 2'd0 || sw_addr[1:0] == 2'd3);
            if (!sw_addr[0])
            begin
                pre_write_next = 1'b0;
                flags_next     = flags_next & ~iie_pkg::flag_mask(iie_pkg::F_LCWRITE);
            end
            else if (lc_write)
            begin
                pre_write_next = 1'b0;
            end
            else
            begin
                if (pre_write_reg)
                    flags_next = flags_next | iie_pkg::flag_mask(iie_pkg::F_LCWRITE);
                pre_write_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg         <= iie_pkg::flag_mask(iie_pkg::F_BANK2)
                               | iie_pkg::flag_mask(iie_pkg::F_LCWRITE)
                               | iie_pkg::flag_mask(iie_pkg::F_TEXT);
            pre_write_reg     <= 1'b1;
            kbd_latch_reg     <= '0;
            speaker_reg       <= 1'b0;
            trigger_cycle_reg <= '0;
            c800_latch_reg    <= 1'b0;
            io_slot_reg       <= '0;
        end
        else if (fire)
        begin
            flags_reg         <= flags_next;
            pre_write_reg     <= pre_write_next;
            kbd_latch_reg     <= kbd_latch_next;
            speaker_reg       <= speaker_next;
            trigger_cycle_reg <= trigger_cycle_next;
            c800_latch_reg    <= c800_latch_next;
            io_slot_reg       <= io_slot_next;
        end
    end

    // The result carries the state as it stands after this access.
    assign view.read_data   = read_data;
    assign view.driven      = driven;
    assign view.mode_flags  = flags_next;
    assign view.speaker_out = speaker_next;
    assign view.int_exp_rom = c800_latch_next;
    assign view.last_slot   = io_slot_next;

endmodule

// ===== rtl/iie_soft_switch_controller.sv =====
// Top level of the soft switch controller: input register, state update and result register.
`timescale 1ns / 1ps

// Usage
// The req channel carries one bus transaction: a read, a write, a keyboard
// latch load or a soft reset, together with the button, paddle, cycle count
// and blanking inputs sampled for it. The rsp channel returns exactly one
// transaction per request: the read byte with its driven flag, and the mode
// flags, speaker level, $C800 ownership and last slot after the access.
// The cfg channel writes the machine model; it is always ready and must only
// be used while no request is still in flight.
// A request passes through two registers: the accepting edge loads the request
// register, and the decode and state update land in the response register
// once that register is free. Throughput is one transaction per cycle while
// the receiver does not stall, the state update between those two registers
// being combinational.
// A stalled receiver holds the response register; the request register still
// takes one more transaction, and req.ready drops only once both are full.
// Reset (rst_n low) empties both registers, sets the model to enhanced and
// puts the switches in their power-up state: bank 2, language card write
// enabled with the pre-write armed, text mode, keyboard latch clear.

module iie_soft_switch_controller
(
    input logic       clk,
    input logic       rst_n,
    iie_req_if.sink   req,
    iie_rsp_if.source rsp,
    iie_cfg_if.sink   cfg
);

    logic               item_valid_reg;
    iie_pkg::iie_item_t item_reg;
    logic               rsp_valid_reg;
    iie_pkg::iie_view_t rsp_reg;
    logic [1:0]         machine_model_reg;

    logic               advance;
    logic               accept;
    iie_pkg::iie_view_t view;

    // The held request moves on when the response register is free or emptying.
    assign advance    = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready  = !item_valid_reg || advance;
    assign accept     = req.valid && req.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            machine_model_reg <= iie_pkg::MODEL_ENHANCED;
        else if (cfg.valid)
            machine_model_reg <= cfg.machine_model;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (accept)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op          <= req.op;
            item_reg.address     <= req.address;
            item_reg.key_code    <= req.key_code;
            item_reg.buttons     <= req.buttons;
            item_reg.paddle_axes <= req.paddle_axes;
            item_reg.now_cycle   <= req.now_cycle;
            item_reg.in_vbl      <= req.in_vbl;
        end
    end

    iie_state u_state
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .machine_model (machine_model_reg),
        .item          (item_reg),
        .view          (view)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= view;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rsp_reg.read_data;
    assign rsp.driven      = rsp_reg.driven;
    assign rsp.mode_flags  = rsp_reg.mode_flags;
    assign rsp.speaker_out = rsp_reg.speaker_out;
    assign rsp.int_exp_rom = rsp_reg.int_exp_rom;
    assign rsp.last_slot   = rsp_reg.last_slot;

endmodule
